// ----- rtl/positional_list_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define PLE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// Next-cycle implication.
`define PLE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

// ----- rtl/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Command, selector and status codes, field widths and cell control type.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int unsigned DepthDef    = 16;
  localparam int unsigned DataBitsDef = 32;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned WhereW = 2;
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PEEK  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [WhereW-1:0] {
    WHERE_HEAD = 2'd0,
    WHERE_TAIL = 2'd1,
    WHERE_POS  = 2'd2
  } where_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Per-cell update select, one hot or all zero (hold).
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctrl_t;

endpackage

// ----- rtl/plist_if.sv -----
// ----------------------------------------------------------------------------
// Positional list engine channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface plist_in_if
  import plist_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [WhereW-1:0] where;
  logic [PosW-1:0]   position;
  logic [ValueW-1:0] value;

  modport source (output valid, cmd, where, position, value, input ready);
  modport sink   (input valid, cmd, where, position, value, output ready);
endinterface

interface plist_out_if
  import plist_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [ValueW-1:0] read_value;
  logic [CountW-1:0] count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

// ----- rtl/plist_cell.sv -----
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry; loads a new word or takes a neighbor's word.
// ----------------------------------------------------------------------------
module plist_cell
  import plist_pkg::*;
#(
  parameter int unsigned DATA_BITS = DataBitsDef
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [DATA_BITS-1:0] left_i,
  input  logic [DATA_BITS-1:0] right_i,
  input  logic [DATA_BITS-1:0] new_i,
  output logic [DATA_BITS-1:0] data_o
);

  logic [DATA_BITS-1:0] data_q, data_d;

  // Pick the next word: new data, shift right from left, shift left from right
  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.load) begin
      data_d = new_i;
    end else if (ctrl_i.from_left) begin
      data_d = left_i;
    end else if (ctrl_i.from_right) begin
      data_d = right_i;
    end else begin
      // hold
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/positional_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list with push, peek and pop at head, tail or position, and clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command beat (cmd, where, position, value); out_o returns
//   exactly one result beat (status, read_value, count) per command.
//   The list lives in a row of DEPTH cells, head in cell 0. A push shifts the
//   cells at and after the insert point one place toward the tail in the same
//   cycle; a pop shifts the cells after the removed one toward the head.
//   The result is registered and shown in the cycle after the command beat is
//   taken. One command is taken per cycle while the receiver takes each result;
//   the cell update and the one-entry output register set this rate.
//   A peek or pop reads its word through one DEPTH-way select on the cells.
//   Reset empties the list (count zero) and drops any pending result; cell
//   contents are not cleared and are never read before being written.
//   When the receiver stalls, the result holds on out_o and in_i.ready drops
//   until the result beat is taken; in_i.ready is high while out_o is empty or
//   being drained in the same cycle.
// ----------------------------------------------------------------------------
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core
  import plist_pkg::*;
#(
  parameter int unsigned DEPTH     = DepthDef,
  parameter int unsigned DATA_BITS = DataBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plist_in_if.sink   in_i,
  plist_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_e                 cmd;
  where_e               where;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx;
  logic                 in_fire;
  logic                 push_ok, pop_ok, read_ok;
  status_e              status_d;
  logic [63:0]          value_ext;
  logic [DATA_BITS-1:0] new_data;
  logic [DATA_BITS-1:0] cell_data [DEPTH];
  cell_ctrl_t           cell_ctrl [DEPTH];
  logic [63:0]          rd_ext;
  logic [ValueW-1:0]    rd_value;

  logic                 out_valid_q;
  status_e              status_q;
  logic [ValueW-1:0]    read_value_q;
  logic [CountW-1:0]    count_out_q;

  assign cmd       = cmd_e'(in_i.cmd);
  assign where     = where_e'(in_i.where);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire   = in_i.valid && in_i.ready;

  assign value_ext = 64'(in_i.value);
  assign new_data  = value_ext[DATA_BITS-1:0];

  // Decode the command into a status, a cell index and the kind of update
  always_comb begin
    status_d = ST_OK;
    idx      = '0;
    push_ok  = 1'b0;
    read_ok  = 1'b0;
    unique case (cmd)
      CMD_CLEAR: begin
        status_d = ST_OK;
      end
      CMD_PUSH: begin
        if (32'(count_q) >= DEPTH) begin
          status_d = ST_FULL;
        end else begin
          unique case (where)
            WHERE_HEAD: begin
              push_ok = 1'b1;
            end
            WHERE_TAIL: begin
              idx     = count_q;
              push_ok = 1'b1;
            end
            WHERE_POS: begin
              if (in_i.position != '0 && 32'(in_i.position) <= 32'(count_q)) begin
                idx     = CntW'(32'(in_i.position) - 32'd1);
                push_ok = 1'b1;
              end else begin
                status_d = ST_OOB;
              end
            end
            default: status_d = ST_OOB;
          endcase
        end
      end
      CMD_PEEK, CMD_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          unique case (where)
            WHERE_HEAD: begin
              read_ok = 1'b1;
            end
            WHERE_TAIL: begin
              idx     = count_q - CntW'(1);
              read_ok = 1'b1;
            end
            WHERE_POS: begin
              if (in_i.position != '0 && 32'(in_i.position) <= 32'(count_q)) begin
                idx     = CntW'(32'(in_i.position) - 32'd1);
                read_ok = 1'b1;
              end else begin
                status_d = ST_OOB;
              end
            end
            default: status_d = ST_OOB;
          endcase
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign pop_ok = read_ok && (cmd == CMD_POP);

  // Next entry count
  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      if (cmd == CMD_CLEAR) begin
        count_d = '0;
      end else if (push_ok) begin
        count_d = count_q + CntW'(1);
      end else if (pop_ok) begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  // Per-cell controls: load at the index, shift toward tail or head around it
  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      cell_ctrl[i].load       = in_fire && push_ok && (CntW'(i) == idx);
      cell_ctrl[i].from_left  = in_fire && push_ok && (CntW'(i) > idx) &&
                                (CntW'(i) <= count_q);
      cell_ctrl[i].from_right = in_fire && pop_ok && (CntW'(i) >= idx) &&
                                ((CntW'(i) + CntW'(1)) < count_q);
    end
  end

  // Row of cells, each fed by its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_BITS-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = new_data;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    plist_cell #(
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .left_i  (left),
      .right_i (right),
      .new_i   (new_data),
      .data_o  (cell_data[g])
    );
  end

  // Read the addressed word, zero unless the read is valid
  assign rd_ext   = read_ok ? 64'(cell_data[idx[IdxW-1:0]]) : 64'd0;
  assign rd_value = rd_ext[ValueW-1:0];

  // Hold count and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q     <= status_d;
      read_value_q <= rd_value;
      count_out_q  <= CountW'(count_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.read_value = read_value_q;
  assign out_o.count      = count_out_q;

  `PLE_ASSERT_IMPL(a_count_bound, 1'b1, 32'(count_q) <= DEPTH)
  `PLE_ASSERT_NEXT(a_clear_empties, in_fire && cmd == CMD_CLEAR, count_q == '0)
  `PLE_ASSERT_NEXT(a_full_keeps, in_fire && status_d == ST_FULL,
                   count_q == $past(count_q))
  `PLE_ASSERT_IMPL(a_stall_blocks, out_valid_q && !out_o.ready, !in_i.ready)

endmodule
